// ===== design/tzsp_header_deframer_unit_macros.svh =====
// Assertion macros for the TZSP deframer checker.
`ifndef TZSP_HEADER_DEFRAMER_UNIT_MACROS_SVH
`define TZSP_HEADER_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TZSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tzsp check failed");

// Next-cycle implication, disabled during reset.
`define TZSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tzsp check failed");

`endif

// ===== design/tzsp_pkg.sv =====
package tzsp_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_VERSION  = 3'd2;
  localparam logic [2:0] ST_TYPE     = 3'd3;
  localparam logic [2:0] ST_ENCAP    = 3'd4;
  localparam logic [2:0] ST_OVERRUN  = 3'd5;
  localparam logic [2:0] ST_SHORTPAY = 3'd6;

  localparam logic [15:0] MIN_FRAME_EXCL = 16'd10;
  localparam logic [15:0] MIN_PAYLOAD    = 16'd6;
  localparam logic [16:0] WALK_TAIL      = 17'd2;

  // Classified byte handed from the parser to the output side.
  typedef struct packed {
    logic [7:0] data;
    logic       is_payload;
    logic       frame_end;
    logic [2:0] status;
  } item_t;

endpackage

// ===== design/tzsp_front.sv =====
module tzsp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic [15:0]        in_frame_length,
  input  logic               q_full,
  output logic               q_push,
  output tzsp_pkg::item_t    q_item
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TAG     = 3'd1;
  localparam logic [2:0] PH_TAGLEN  = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [2:0]  verdict_r, verdict_nxt;

  logic        first, last, accept, near_end;
  logic [15:0] len;
  logic [2:0]  ph;
  logic [7:0]  sk, sk_dec;
  logic [16:0] pos_inc, len_m_pos;
  logic [15:0] left_after;
  logic [2:0]  final_status;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    first      = (pos_r == 16'd0);
    len        = first ? in_frame_length : len_r;
    ph         = first ? PH_HEADER : phase_r;
    sk         = first ? 8'd0 : skip_r;
    pos_inc    = {1'b0, pos_r} + 17'd1;
    last       = (pos_inc >= {1'b0, len});
    left_after = last ? 16'd0 : (len - pos_inc[15:0]);
    len_m_pos  = {1'b0, len} - {1'b0, pos_r};
    near_end   = !len_m_pos[16] && (len_m_pos <= tzsp_pkg::WALK_TAIL);
    sk_dec     = (sk != 8'd0) ? sk - 8'd1 : sk;

    phase_nxt   = ph;
    verdict_nxt = first ? tzsp_pkg::ST_OK : verdict_r;
    skip_nxt    = sk;

    case (ph)
      PH_HEADER: begin
        if (pos_r == 16'd0) begin
          if (len <= tzsp_pkg::MIN_FRAME_EXCL) begin
            verdict_nxt = tzsp_pkg::ST_SHORT;
            phase_nxt   = PH_DISCARD;
          end else if (in_data_byte != 8'd1) begin
            verdict_nxt = tzsp_pkg::ST_VERSION;
            phase_nxt   = PH_DISCARD;
          end
        end else if (pos_r == 16'd1) begin
          if (in_data_byte > 8'd1) begin
            verdict_nxt = tzsp_pkg::ST_TYPE;
            phase_nxt   = PH_DISCARD;
          end
        end else if (pos_r == 16'd2) begin
          if (in_data_byte != 8'd0) begin
            verdict_nxt = tzsp_pkg::ST_ENCAP;
            phase_nxt   = PH_DISCARD;
          end
        end else begin
          if (in_data_byte != 8'd1) begin
            verdict_nxt = tzsp_pkg::ST_ENCAP;
            phase_nxt   = PH_DISCARD;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
      PH_TAG: begin
        if (near_end) begin
          verdict_nxt = tzsp_pkg::ST_SHORTPAY;
          phase_nxt   = PH_DISCARD;
        end else if (in_data_byte == 8'd1) begin
          if (left_after < tzsp_pkg::MIN_PAYLOAD) begin
            verdict_nxt = tzsp_pkg::ST_SHORTPAY;
            phase_nxt   = PH_DISCARD;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else if (in_data_byte != 8'd0) begin
          phase_nxt = PH_TAGLEN;
        end
      end
      PH_TAGLEN: begin
        if ({8'd0, in_data_byte} > left_after) begin
          verdict_nxt = tzsp_pkg::ST_OVERRUN;
          phase_nxt   = PH_DISCARD;
        end else if (in_data_byte == 8'd0) begin
          phase_nxt = PH_TAG;
        end else begin
          skip_nxt  = in_data_byte;
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = sk_dec;
        if (sk_dec == 8'd0) phase_nxt = PH_TAG;
      end
      default: begin
      end
    endcase

    // a frame that ends without an error anywhere but in the payload is short
    final_status = ((verdict_nxt == tzsp_pkg::ST_OK) && (phase_nxt != PH_PAYLOAD))
                   ? tzsp_pkg::ST_SHORTPAY : verdict_nxt;

    q_item.is_payload = (ph == PH_PAYLOAD);
    q_item.data       = (ph == PH_PAYLOAD) ? in_data_byte : 8'd0;
    q_item.frame_end  = last;
    q_item.status     = last ? final_status : tzsp_pkg::ST_OK;

    pos_nxt = last ? 16'd0 : pos_inc[15:0];
    if (last) begin
      phase_nxt = PH_HEADER;
      skip_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 16'd0;
      len_r     <= 16'd0;
      phase_r   <= PH_HEADER;
      skip_r    <= 8'd0;
      verdict_r <= tzsp_pkg::ST_OK;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      len_r     <= len;
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      verdict_r <= verdict_nxt;
    end
  end

endmodule

// ===== design/tzsp_queue.sv =====
module tzsp_queue #(
  parameter int DEPTH = tzsp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tzsp_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output tzsp_pkg::item_t  head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tzsp_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== design/tzsp_back.sv =====
module tzsp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  tzsp_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_out_byte,
  output logic             out_is_payload,
  output logic             out_frame_end,
  output logic [2:0]       out_status,
  output logic [31:0]      out_accepted_total,
  output logic [31:0]      out_dropped_total
);

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        pay_r, end_r;
  logic [2:0]  status_r;
  logic [31:0] acc_total_r, drop_total_r;
  logic [31:0] acc_r, acc_nxt, drop_r, drop_nxt;
  logic        load, ok_frame;

  assign load     = q_not_empty && (!valid_r || !out_stall);
  assign q_pop    = load;
  assign ok_frame = (q_item.status == tzsp_pkg::ST_OK);

  always_comb begin
    acc_nxt  = acc_r;
    drop_nxt = drop_r;
    if (q_item.frame_end) begin
      if (ok_frame) begin
        if (acc_r != 32'hFFFF_FFFF) acc_nxt = acc_r + 32'd1;
      end else begin
        if (drop_r != 32'hFFFF_FFFF) drop_nxt = drop_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= 32'd0;
      drop_r  <= 32'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      acc_r   <= acc_nxt;
      drop_r  <= drop_nxt;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r       <= q_item.data;
      pay_r        <= q_item.is_payload;
      end_r        <= q_item.frame_end;
      status_r     <= q_item.status;
      acc_total_r  <= q_item.frame_end ? acc_nxt : 32'd0;
      drop_total_r <= q_item.frame_end ? drop_nxt : 32'd0;
    end
  end

  assign out_valid          = valid_r;
  assign out_out_byte       = byte_r;
  assign out_is_payload     = pay_r;
  assign out_frame_end      = end_r;
  assign out_status         = status_r;
  assign out_accepted_total = acc_total_r;
  assign out_dropped_total  = drop_total_r;

endmodule

// ===== design/tzsp_header_deframer_unit.sv =====
// An accepted input item is written into the queue and then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; the parser decides each byte
// combinationally and a small queue separates it from the output register.
// Reset (rst_n low, synchronous) clears the parse state, the queue, the output
// valid and both frame totals; the block takes items in the cycle after reset.
module tzsp_header_deframer_unit #(
  parameter int QUEUE_DEPTH = tzsp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_frame_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_is_payload,
  output logic        out_frame_end,
  output logic [2:0]  out_status,
  output logic [31:0] out_accepted_total,
  output logic [31:0] out_dropped_total
);

  tzsp_pkg::item_t push_item, head_item;
  logic            push, full, pop, not_empty;

  tzsp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_frame_length (in_frame_length),
    .q_full          (full),
    .q_push          (push),
    .q_item          (push_item)
  );

  tzsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  tzsp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (not_empty),
    .q_item             (head_item),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_is_payload     (out_is_payload),
    .out_frame_end      (out_frame_end),
    .out_status         (out_status),
    .out_accepted_total (out_accepted_total),
    .out_dropped_total  (out_dropped_total)
  );

endmodule

// ===== design/tzsp_checker.sv =====
`include "tzsp_header_deframer_unit_macros.svh"

module tzsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_out_byte,
  input logic        out_is_payload,
  input logic        out_frame_end,
  input logic [2:0]  out_status,
  input logic [31:0] out_accepted_total,
  input logic [31:0] out_dropped_total
);

  // a stalled item holds its payload
  `TZSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_out_byte) && $stable(out_frame_end) && $stable(out_status))

  // mid-frame items carry no verdict and no totals
  `TZSP_ASSERT_NOW(a_mid_zero, clk, rst_n, out_valid && !out_frame_end, out_status == tzsp_pkg::ST_OK && out_accepted_total == 32'd0 && out_dropped_total == 32'd0)

  // header, tag and discarded bytes are blanked
  `TZSP_ASSERT_NOW(a_non_pay_zero, clk, rst_n, out_valid && !out_is_payload, out_out_byte == 8'd0)

  // a frame that reached its payload always ends accepted
  `TZSP_ASSERT_NOW(a_pay_end_ok, clk, rst_n, out_valid && out_is_payload && out_frame_end, out_status == tzsp_pkg::ST_OK)

endmodule

bind tzsp_header_deframer_unit tzsp_checker u_checker (.*);
